// File: rtl/core/bdq_pkg.sv
// Package for the button debounce event queue.
// Types, codes and field widths shared by all rtl/core files; no dependencies.
package bdq_pkg;

    localparam int BUTTON_COUNT     = 2;
    localparam int QUEUE_SLOTS_DEF  = 8;
    localparam int PUSH_N           = 2 * BUTTON_COUNT;
    localparam int BTN_W            = 1;
    localparam int NOW_W            = 32;
    localparam int DEB_W            = 16;
    localparam int S_TDATA_W        = 40;
    localparam int S_TUSER_W        = 2;
    localparam int M_TDATA_W        = 8;
    localparam int M_TUSER_W        = 1;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic             REG_DEBOUNCE   = 1'b0;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_POP    = 2'd1,
        KIND_INIT   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CODE_PRESSED  = 2'd0,
        CODE_RELEASED = 2'd1,
        CODE_SHORT    = 2'd2
    } t_code;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        t_code            code;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_push_req;

endpackage

// File: rtl/core/button_debounce_event_queue.sv
// Top level: time-based debounce of two buttons with an event queue.
// Depends on bdq_pkg and bdq_event_fifo.
//
//  channel  | ports       | fields (low bit up)
//  ---------+-------------+---------------------------------------------------
//  s        | i_s_*       | tdata: raw_pressed[1:0], now_ms[33:2]; tuser: kind
//  m        | o_m_*       | tdata: event_button, event_code, stable_levels; tuser: event_valid
//  apb      | i_p*, o_p*  | reg 0 @0x0: debounce_ms[15:0]
//
// One request per cycle sustained while m accepts; each request passes the input
// register, then the result register. A two-entry output (result register plus
// skid) keeps s ready while one result waits. Sync active-low reset clears levels,
// change times and queue pointers; queue storage is not cleared.
module button_debounce_event_queue #(
    parameter int QUEUE_SLOTS = bdq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bdq_pkg::S_TDATA_W-1:0] i_s_tdata,  // raw_pressed, now_ms, pad
    input  logic [bdq_pkg::S_TUSER_W-1:0] i_s_tuser,  // kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bdq_pkg::M_TDATA_W-1:0] o_m_tdata,  // event_button, event_code,
                                                      // stable_levels, pad
    output logic [bdq_pkg::M_TUSER_W-1:0] o_m_tuser,  // event_valid
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bdq_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [bdq_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [bdq_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import bdq_pkg::*;

    // configuration
    logic [DEB_W-1:0] r_debounce;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_DEBOUNCE) ? {{(PDATA_W-DEB_W){1'b0}}, r_debounce}
                                                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && (i_paddr[2] == REG_DEBOUNCE)) begin
            r_debounce <= i_pwdata[DEB_W-1:0];
        end
    end

    // input register
    logic                    r_in_valid;
    logic [S_TUSER_W-1:0]    r_in_kind;
    logic [BUTTON_COUNT-1:0] r_in_raw;
    logic [NOW_W-1:0]        r_in_now;
    logic                    r_skid_valid;
    logic                    fire;

    assign fire       = r_in_valid && !r_skid_valid;
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind <= i_s_tuser;
            r_in_raw  <= i_s_tdata[BUTTON_COUNT-1:0];
            r_in_now  <= i_s_tdata[BUTTON_COUNT +: NOW_W];
        end
    end

    // debounce state
    logic [BUTTON_COUNT-1:0] r_last, n_last;
    logic [BUTTON_COUNT-1:0] r_stable, n_stable;
    logic [NOW_W-1:0]        r_ct [BUTTON_COUNT];
    logic [NOW_W-1:0]        n_ct [BUTTON_COUNT];
    t_push_req [PUSH_N-1:0]  push;
    logic                    pop;
    logic                    fifo_empty;
    t_event                  fifo_head;

    always_comb begin
        logic [NOW_W-1:0] elapsed;
        n_last   = r_last;
        n_stable = r_stable;
        n_ct     = r_ct;
        push     = '0;
        pop      = 1'b0;
        elapsed  = '0;
        if (fire) begin
            unique case (t_kind'(r_in_kind))
                KIND_SAMPLE: begin
                    for (int b = 0; b < BUTTON_COUNT; b++) begin
                        if (r_in_raw[b] != r_last[b]) begin
                            n_last[b] = r_in_raw[b];
                            n_ct[b]   = r_in_now;
                        end
                        elapsed = r_in_now - n_ct[b];
                        if ((elapsed >= {{(NOW_W-DEB_W){1'b0}}, r_debounce})
                            && (n_stable[b] != n_last[b])) begin
                            n_stable[b]             = n_last[b];
                            push[2*b].valid         = 1'b1;
                            push[2*b].ev.button     = BTN_W'(b);
                            push[2*b].ev.code       = n_last[b] ? CODE_PRESSED
                                                                : CODE_RELEASED;
                            push[2*b+1].valid       = !n_last[b];
                            push[2*b+1].ev.button   = BTN_W'(b);
                            push[2*b+1].ev.code     = CODE_SHORT;
                        end
                    end
                end
                KIND_POP: begin
                    pop = 1'b1;
                end
                KIND_INIT: begin
                    for (int b = 0; b < BUTTON_COUNT; b++) begin
                        n_last[b]   = r_in_raw[b];
                        n_stable[b] = r_in_raw[b];
                        n_ct[b]     = r_in_now;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_stable <= '0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_ct[b] <= '0;
            end
        end else begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_ct     <= n_ct;
        end
    end

    bdq_event_fifo #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_empty (fifo_empty),
        .o_head  (fifo_head)
    );

    // result and output stage
    logic                 res_valid;
    logic [M_TDATA_W-1:0] res_data;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_out_user;
    logic [M_TDATA_W-1:0] r_skid_data;
    logic                 r_skid_user;

    assign res_valid = pop && !fifo_empty;
    assign res_data  = {{(M_TDATA_W-BTN_W-2-BUTTON_COUNT){1'b0}}, n_stable,
                        res_valid ? fifo_head.code   : CODE_PRESSED,
                        res_valid ? fifo_head.button : {BTN_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_m_tready || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || fire;
            r_skid_valid <= 1'b0;
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_m_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else if (fire) begin
                r_out_data <= res_data;
                r_out_user <= res_valid;
            end
        end else if (fire) begin
            r_skid_data <= res_data;
            r_skid_user <= res_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// File: rtl/core/bdq_event_fifo.sv
// Ring FIFO of button events, up to PUSH_N pushes per cycle in order, one pop.
// Depends on bdq_pkg.
module bdq_event_fifo #(
    parameter int QUEUE_SLOTS = bdq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  bdq_pkg::t_push_req [bdq_pkg::PUSH_N-1:0]   i_push,
    input  logic                                       i_pop,
    output logic                                       o_empty,
    output bdq_pkg::t_event                            o_head
);
    import bdq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_SLOTS);

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    t_event           r_mem [QUEUE_SLOTS];
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] wr_addr [PUSH_N];
    logic [PUSH_N-1:0] wr_en;

    assign o_empty = (r_rp == r_wp);
    assign o_head  = r_mem[r_rp];

    // pushes are applied in order; a push into a full ring is dropped
    always_comb begin
        n_wp = r_wp;
        for (int k = 0; k < PUSH_N; k++) begin
            wr_en[k]   = 1'b0;
            wr_addr[k] = n_wp;
            if (i_push[k].valid && (f_next(n_wp) != r_rp)) begin
                wr_en[k] = 1'b1;
                n_wp     = f_next(n_wp);
            end
        end
        n_rp = (i_pop && !o_empty) ? f_next(r_rp) : r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
        end else begin
            r_rp <= n_rp;
            r_wp <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PUSH_N; k++) begin
            if (wr_en[k]) begin
                r_mem[wr_addr[k]] <= i_push[k].ev;
            end
        end
    end

endmodule

// File: rtl/core/bdq_checker.sv
// Port-level checks for button_debounce_event_queue, bound to the top level.
// Depends on bdq_pkg and the top level's ports.
module bdq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [bdq_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [bdq_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import bdq_pkg::*;

    // no event: button and code fields are zero
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[2:0] == 3'b000)
        else $error("event fields set without event");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:1] != 2'd3 && o_m_tdata[M_TDATA_W-1:5] == '0)
        else $error("bad result encoding");

    a_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_s_tready && !o_m_tvalid)
        else $error("channel state after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                       && $stable(o_m_tuser))
        else $error("stalled request changed");

endmodule

bind button_debounce_event_queue bdq_checker u_bdq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
